>>> rtl/adsc_pkg.sv
// Package with the shared types and constants of the automatic door stepper controller.
`default_nettype none

package adsc_pkg;

   localparam int unsigned RUN_WIDTH   = 16;
   localparam int unsigned PHASE_COUNT = 4;
   localparam int unsigned PHASE_WIDTH = $clog2(PHASE_COUNT);
   localparam int unsigned COIL_WIDTH  = PHASE_COUNT;
   localparam int unsigned CODE_WIDTH  = 8;

   localparam logic [RUN_WIDTH-1:0]  RESET_RUN_TICKS = RUN_WIDTH'(2000);
   localparam logic [CODE_WIDTH-1:0] MSG_NONE        = CODE_WIDTH'(0);
   localparam logic [CODE_WIDTH-1:0] MSG_SENSOR      = CODE_WIDTH'(84);
   localparam logic [CODE_WIDTH-1:0] MSG_KEY         = CODE_WIDTH'(85);

   typedef struct packed {
      logic                   opening_dir;
      logic [RUN_WIDTH-1:0]   ticks_left;
      logic [PHASE_WIDTH-1:0] phase_count;
      logic                   press_latched;
      logic                   key_hold;
   } door_state_type;

   typedef struct packed {
      logic [COIL_WIDTH-1:0] coil_drive;
      logic                  door_opening;
      logic                  announce;
      logic [CODE_WIDTH-1:0] voice_code;
   } door_result_type;

endpackage

`default_nettype wire

>>> rtl/adsc_step.sv
// Per-tick door logic and motor step: next state and result for one transaction.
`default_nettype none

module adsc_step (
   input  wire logic                          key_pressed,
   input  wire logic                          person_present,
   input  wire logic [adsc_pkg::RUN_WIDTH-1:0] run_ticks,
   input  wire adsc_pkg::door_state_type      state_cur,
   output adsc_pkg::door_state_type           state_nxt,
   output adsc_pkg::door_result_type          result
);
   import adsc_pkg::*;

   door_state_type        st;
   logic [CODE_WIDTH-1:0] code;
   logic [COIL_WIDTH-1:0] coils;

   always_comb begin
      st    = state_cur;
      code  = MSG_NONE;
      coils = '0;

      if (key_pressed) begin
         if (!st.press_latched) begin
            st.press_latched = 1'b1;
            if (!st.opening_dir) begin
               st.opening_dir = 1'b1;
               st.ticks_left  = run_ticks;
               st.key_hold    = 1'b1;
            end
            code = MSG_KEY;
         end
      end else begin
         st.press_latched = 1'b0;
      end

      if (st.key_hold) begin
         if (st.ticks_left == '0) begin
            st.key_hold = 1'b0;
         end
      end else if (person_present) begin
         if (!st.opening_dir) begin
            st.opening_dir = 1'b1;
            st.ticks_left  = run_ticks;
            code           = MSG_SENSOR;
         end
      end else begin
         if (st.opening_dir) begin
            st.opening_dir = 1'b0;
            st.ticks_left  = run_ticks;
         end
      end

      if (st.ticks_left != '0) begin
         st.ticks_left = st.ticks_left - RUN_WIDTH'(1);
         if (st.opening_dir) begin
            coils = COIL_WIDTH'(1 << (COIL_WIDTH - 1)) >> st.phase_count;
         end else begin
            coils = COIL_WIDTH'(1) << st.phase_count;
         end
         st.phase_count = st.phase_count + PHASE_WIDTH'(1);
      end
   end

   assign state_nxt           = st;
   assign result.coil_drive   = coils;
   assign result.door_opening = st.opening_dir;
   assign result.announce     = (code != MSG_NONE);
   assign result.voice_code   = code;

endmodule

`default_nettype wire

>>> rtl/auto_door_stepper_controller_unit.sv
// Top level of the automatic door stepper controller with input and result registers.
// A transaction accepted into the input register passes through the step logic into the
// result register, unless an earlier result is still stalled on the result side.
// Throughput: one transaction per cycle while the result side is not stalled, set by the
// combinational step logic between the input register and the result register.
// Reset: synchronous; run_ticks and ticks_left go to 2000; valids and door state clear.
`default_nettype none

module auto_door_stepper_controller_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_key_pressed,
   input  wire logic                           req_person_present,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [adsc_pkg::COIL_WIDTH-1:0] rsp_coil_drive,
   output      logic                           rsp_door_opening,
   output      logic                           rsp_announce,
   output      logic [adsc_pkg::CODE_WIDTH-1:0] rsp_voice_code,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [adsc_pkg::RUN_WIDTH-1:0]  csr_run_ticks
);
   import adsc_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_key_ff, in_person_ff;
   logic                 out_valid_ff, out_valid_in;
   door_result_type      out_ff;
   door_state_type       state_ff, state_in;
   door_result_type      step_result;
   logic [RUN_WIDTH-1:0] run_ticks_ff;
   logic                 advance;
   logic                 req_fire;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   adsc_step u_step (
      .key_pressed    (in_key_ff),
      .person_present (in_person_ff),
      .run_ticks      (run_ticks_ff),
      .state_cur      (state_ff),
      .state_nxt      (state_in),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         run_ticks_ff           <= RESET_RUN_TICKS;
         state_ff.opening_dir   <= 1'b0;
         state_ff.ticks_left    <= RESET_RUN_TICKS;
         state_ff.phase_count   <= '0;
         state_ff.press_latched <= 1'b0;
         state_ff.key_hold      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            run_ticks_ff <= csr_run_ticks;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_key_ff    <= req_key_pressed;
         in_person_ff <= req_person_present;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_coil_drive   = out_ff.coil_drive;
   assign rsp_door_opening = out_ff.door_opening;
   assign rsp_announce     = out_ff.announce;
   assign rsp_voice_code   = out_ff.voice_code;

endmodule

`default_nettype wire

>>> rtl/adsc_checker.sv
// Port-level assertion checker for the automatic door stepper controller, bound to the top level.
`default_nettype none

module adsc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [adsc_pkg::COIL_WIDTH-1:0] rsp_coil_drive,
   input wire logic                           rsp_door_opening,
   input wire logic                           rsp_announce,
   input wire logic [adsc_pkg::CODE_WIDTH-1:0] rsp_voice_code
);
   import adsc_pkg::*;

   a_coil_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_coil_drive))
      else $error("coil drive has more than one coil on");

   a_code_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_announce |-> rsp_voice_code == MSG_KEY || rsp_voice_code == MSG_SENSOR)
      else $error("announced transaction carries an unknown voice code");

   a_code_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_announce |-> rsp_voice_code == MSG_NONE)
      else $error("voice code set without an announcement");

   a_sensor_opens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_voice_code == MSG_SENSOR |-> rsp_door_opening)
      else $error("sensor welcome without the door opening");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coil_drive)
         && $stable(rsp_voice_code))
      else $error("stalled result transaction changed");

endmodule

bind auto_door_stepper_controller_unit adsc_checker u_adsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_coil_drive   (rsp_coil_drive),
   .rsp_door_opening (rsp_door_opening),
   .rsp_announce     (rsp_announce),
   .rsp_voice_code   (rsp_voice_code)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the automatic door stepper controller with a built-in tick predictor.
`timescale 1ns / 1ps

module testbench;
   import adsc_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_key_pressed = 1'b0;
   logic                   req_person_present = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COIL_WIDTH-1:0]  rsp_coil_drive;
   logic                   rsp_door_opening;
   logic                   rsp_announce;
   logic [CODE_WIDTH-1:0]  rsp_voice_code;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [RUN_WIDTH-1:0]   csr_run_ticks = '0;

   logic [RUN_WIDTH-1:0]   run_length;
   logic                   door_opens;
   logic [RUN_WIDTH-1:0]   ticks_remaining;
   logic [PHASE_WIDTH-1:0] coil_phase;
   logic                   key_latched;
   logic                   key_holds_door;

   door_result_type        door_results_due[$];
   int unsigned            req_gap_pct = 0;
   int unsigned            rsp_stall_pct = 0;
   int unsigned            failures = 0;

   auto_door_stepper_controller_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_pressed    (req_key_pressed),
      .req_person_present (req_person_present),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_drive     (rsp_coil_drive),
      .rsp_door_opening   (rsp_door_opening),
      .rsp_announce       (rsp_announce),
      .rsp_voice_code     (rsp_voice_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_run_ticks      (csr_run_ticks)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic door_result_type advance_door_tick(input logic key, input logic person);
      door_result_type r;
      int unsigned     p;
      r = '0;
      r.voice_code = MSG_NONE;
      if (key) begin
         if (!key_latched) begin
            key_latched = 1'b1;
            if (!door_opens) begin
               door_opens = 1'b1;
               ticks_remaining = run_length;
               key_holds_door = 1'b1;
            end
            r.voice_code = MSG_KEY;
         end
      end else begin
         key_latched = 1'b0;
      end
      if (key_holds_door) begin
         if (ticks_remaining == 0) begin
            key_holds_door = 1'b0;
         end
      end else if (person) begin
         if (!door_opens) begin
            door_opens = 1'b1;
            ticks_remaining = run_length;
            r.voice_code = MSG_SENSOR;
         end
      end else if (door_opens) begin
         door_opens = 1'b0;
         ticks_remaining = run_length;
      end
      if (ticks_remaining != 0) begin
         ticks_remaining = ticks_remaining - 1'b1;
         p = int'(coil_phase) + 1;
         if (door_opens) begin
            r.coil_drive = COIL_WIDTH'(1) << (COIL_WIDTH - p);
         end else begin
            r.coil_drive = COIL_WIDTH'(1) << (p - 1);
         end
         coil_phase = (p >= PHASE_COUNT) ? '0 : PHASE_WIDTH'(p);
      end
      r.door_opening = door_opens;
      r.announce = (r.voice_code != MSG_NONE);
      return r;
   endfunction

   always @(posedge clock) begin
      door_result_type due;
      if (reset) begin
         run_length = RESET_RUN_TICKS;
         door_opens = 1'b0;
         ticks_remaining = RESET_RUN_TICKS;
         coil_phase = '0;
         key_latched = 1'b0;
         key_holds_door = 1'b0;
         door_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (door_results_due.size() == 0) begin
               $error("result transaction with no expectation waiting");
               failures++;
            end else begin
               due = door_results_due.pop_front();
               if (rsp_coil_drive !== due.coil_drive) begin
                  $error("coil_drive: expected %0d, actual %0d", due.coil_drive, rsp_coil_drive);
                  failures++;
               end
               if (rsp_door_opening !== due.door_opening) begin
                  $error("door_opening: expected %0d, actual %0d",
                         due.door_opening, rsp_door_opening);
                  failures++;
               end
               if (rsp_announce !== due.announce) begin
                  $error("announce: expected %0d, actual %0d", due.announce, rsp_announce);
                  failures++;
               end
               if (rsp_voice_code !== due.voice_code) begin
                  $error("voice_code: expected %0d, actual %0d", due.voice_code, rsp_voice_code);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            run_length = csr_run_ticks;
         end
         if (req_valid && req_ready) begin
            door_results_due.push_back(advance_door_tick(req_key_pressed, req_person_present));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_tick(input logic key, input logic person);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_pressed <= key;
      req_person_present <= person;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (door_results_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_run_ticks(input logic [RUN_WIDTH-1:0] ticks);
      wait_idle();
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_run_ticks <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_reset_run_length();
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_key_hold();
      write_run_ticks(RUN_WIDTH'(3));
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_key_while_opening();
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
   endtask

   task automatic test_zero_run_length();
      write_run_ticks('0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
   endtask

   task automatic test_run_length_extremes();
      write_run_ticks('1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      write_run_ticks(RUN_WIDTH'(1));
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned span;
      int unsigned key_span;
      int unsigned pick;
      logic        person;
      sent = 0;
      while (sent < count) begin
         if (sent % 200 == 0) begin
            pick = $urandom_range(99);
            if (pick < 55) write_run_ticks(RUN_WIDTH'($urandom_range(1, 8)));
            else if (pick < 80) write_run_ticks(RUN_WIDTH'($urandom_range(9, 40)));
            else if (pick < 90) write_run_ticks('0);
            else write_run_ticks(RESET_RUN_TICKS);
         end
         if ($urandom_range(99) < 15) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            span = $urandom_range(1, 10);
            key_span = ($urandom_range(99) < 40) ? $urandom_range(1, span) : 0;
            person = 1'($urandom_range(1));
            for (int unsigned i = 0; i < span; i++) begin
               send_tick(i < key_span, person);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_idling(19, 61);
      test_reset_run_length();
      test_key_hold();
      test_key_while_opening();
      test_zero_run_length();
      test_run_length_extremes();
      test_random_traffic(600);
      set_idling(61, 19);
      test_random_traffic(600);
      set_idling(0, 0);
      test_random_traffic(550);
      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
